// File: hdl/i2c_bitbang_master_assert.svh
// Assertion macros shared by the I2C bit-bang master RTL.
// Uses clk and rst_n of the module in which a macro is expanded.
`ifndef I2C_BITBANG_MASTER_ASSERT_SVH
`define I2C_BITBANG_MASTER_ASSERT_SVH

`ifndef SYNTH
// Condition holds in the same cycle as the trigger
`define I2CBB_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("i2cbb assertion failed");
// Condition holds in the cycle after the trigger
`define I2CBB_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("i2cbb assertion failed");
`else
`define I2CBB_ASSERT_SAME(lbl, trig, cond)
`define I2CBB_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

// File: hdl/i2cbb_pkg.sv
// Package for the I2C bit-bang master: payload and config types, codes, defaults.
// No dependencies.
package i2cbb_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] STEP_TICKS_RST = 16'd4;
    localparam logic [15:0] POLL_TICKS_RST = 16'd2;
    localparam logic [7:0]  POLL_LIMIT_RST = 8'd250;
    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_STEP_TICKS = 2'd0,
        REG_POLL_TICKS = 2'd1,
        REG_POLL_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST1  = 5'd1,
        PH_ST2  = 5'd2,
        PH_SP1  = 5'd3,
        PH_SP2  = 5'd4,
        PH_SP3  = 5'd5,
        PH_WB_D = 5'd6,
        PH_WB_H = 5'd7,
        PH_WB_L = 5'd8,
        PH_RA_R = 5'd9,
        PH_RA_H = 5'd10,
        PH_RA_P = 5'd11,
        PH_RB_L = 5'd12,
        PH_RB_H = 5'd13,
        PH_RB_E = 5'd14,
        PH_AK_D = 5'd15,
        PH_AK_H = 5'd16
    } phase_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] func;
        logic [7:0] tx_byte;
        logic       nack_after_read;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } res_t;

    typedef struct packed {
        logic [15:0] step_ticks;
        logic [15:0] poll_ticks;
        logic [7:0]  ack_poll_limit;
    } cfg_t;

endpackage

// File: hdl/i2cbb_if.sv
// Channel interfaces of the I2C bit-bang master: command, result, config write.
// Depends on i2cbb_pkg.
interface i2cbb_cmd_if;
    logic             valid;
    logic             ready;
    i2cbb_pkg::cmd_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cbb_res_if;
    logic             valid;
    logic             ready;
    i2cbb_pkg::res_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cbb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  idx;
    logic [15:0] wdata;
    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

// File: hdl/i2c_bitbang_master.sv
// I2C bit-bang master top level: config registers, command queue and bus engine.
// Depends on i2cbb_pkg, i2cbb_if, i2cbb_queue and i2cbb_engine.
//
// Usage: every item on the cmd channel is one timing tick. It carries the
// sampled SDA level and, optionally, a command (start, stop, write byte,
// read byte) that is taken only while the engine is idle. For every item
// exactly one result appears on the res channel, in order, giving the SCL
// and SDA line levels, busy and done flags, the last received byte and the
// ACK error flag. Delays are counted in ticks set through the cfg channel
// (step ticks, poll ticks, ACK poll limit), which is always ready and
// should be written only while no command is running.
// Throughput: one item per cycle while the res channel takes results, as the
// engine's sequencer advances by one tick on each accepted item.
// Reset: both lines released high, engine idle, config back to 4, 2, 250.
// Stall: results wait in the engine's output register, items collect in
// the command queue, and cmd.ready drops once the queue is full.
module i2c_bitbang_master #(
    parameter int QUEUE_DEPTH = i2cbb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    i2cbb_cmd_if.sink    cmd,
    i2cbb_res_if.source  res,
    i2cbb_cfg_if.sink    cfg
);
    import i2cbb_pkg::*;

    cfg_t  cfg_reg;

    i2cbb_cmd_if q_ch ();

    assign cfg.ready = 1'b1;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ticks     <= STEP_TICKS_RST;
            cfg_reg.poll_ticks     <= POLL_TICKS_RST;
            cfg_reg.ack_poll_limit <= POLL_LIMIT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.idx)
                REG_STEP_TICKS: cfg_reg.step_ticks     <= cfg.wdata;
                REG_POLL_TICKS: cfg_reg.poll_ticks     <= cfg.wdata;
                REG_POLL_LIMIT: cfg_reg.ack_poll_limit <= cfg.wdata[7:0];
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    i2cbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd),
        .out_ch (q_ch.source)
    );

    i2cbb_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_ch  (q_ch.sink),
        .res_ch (res)
    );

endmodule

// File: hdl/i2cbb_queue.sv
// Front part: accepts command items into a short FIFO towards the bus engine.
// Depends on i2cbb_pkg, i2cbb_if and the assertion macro header.
`include "i2c_bitbang_master_assert.svh"

module i2cbb_queue #(
    parameter int DEPTH = i2cbb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    i2cbb_cmd_if.sink        in_ch,
    i2cbb_cmd_if.source      out_ch
);
    import i2cbb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ch.ready  = (count_reg != FULL_CNT);
    assign out_ch.valid = (count_reg != '0);
    assign out_ch.data  = mem[rd_ptr_reg];

    assign push = in_ch.valid && in_ch.ready;
    assign pop  = out_ch.valid && out_ch.ready;

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_ch.data;
        end
    end

    `I2CBB_ASSERT_NEXT(a_no_overflow, count_reg == FULL_CNT && !pop, count_reg == FULL_CNT)
    `I2CBB_ASSERT_NEXT(a_push_lands, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `I2CBB_ASSERT_SAME(a_ptr_range, 1'b1, wr_ptr_reg <= LAST_PTR && rd_ptr_reg <= LAST_PTR)

endmodule

// File: hdl/i2cbb_engine.sv
// Back part: runs the I2C bus sequence one tick per item, registers each result.
// Depends on i2cbb_pkg, i2cbb_if and the assertion macro header.
`include "i2c_bitbang_master_assert.svh"

module i2cbb_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  i2cbb_pkg::cfg_t  cfg,
    i2cbb_cmd_if.sink        in_ch,
    i2cbb_res_if.source      res_ch
);
    import i2cbb_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [15:0]  delay_count_reg, delay_count_next;
    logic [3:0]   bit_count_reg, bit_count_next;
    logic [7:0]   shift_reg, shift_next;
    logic [7:0]   poll_count_reg, poll_count_next;
    logic         scl_reg, scl_next;
    logic         sda_reg, sda_next;
    logic         error_reg, error_next;
    logic [7:0]   rx_hold_reg, rx_hold_next;
    logic         nack_reg, nack_next;
    logic         done_now;

    logic         out_valid_reg;
    res_t         out_data_reg;

    logic         step;
    logic [15:0]  step_eff, poll_eff, dc_dec;
    logic [3:0]   bc_inc;
    cmd_t         item;

    assign item        = in_ch.data;
    assign in_ch.ready = !out_valid_reg || res_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;
    assign step_eff    = (cfg.step_ticks == '0) ? 16'd1 : cfg.step_ticks;
    assign poll_eff    = (cfg.poll_ticks == '0) ? 16'd1 : cfg.poll_ticks;
    assign dc_dec      = delay_count_reg - 1'b1;
    assign bc_inc      = bit_count_reg + 1'b1;

    // Next state of the bus sequencer for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        delay_count_next = delay_count_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        poll_count_next  = poll_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        error_next       = error_reg;
        rx_hold_next     = rx_hold_reg;
        nack_next        = nack_reg;
        done_now         = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_valid)
            begin
                unique case (item.func)
                    FUNC_START:
                    begin
                        sda_next         = 1'b1;
                        scl_next         = 1'b1;
                        phase_next       = PH_ST1;
                        delay_count_next = step_eff;
                    end
                    FUNC_STOP:
                    begin
                        scl_next         = 1'b0;
                        sda_next         = 1'b0;
                        phase_next       = PH_SP1;
                        delay_count_next = step_eff;
                    end
                    FUNC_WRITE:
                    begin
                        bit_count_next   = '0;
                        scl_next         = 1'b0;
                        sda_next         = item.tx_byte[7];
                        shift_next       = {item.tx_byte[6:0], 1'b0};
                        phase_next       = PH_WB_D;
                        delay_count_next = step_eff;
                    end
                    FUNC_READ:
                    begin
                        sda_next         = 1'b1;
                        bit_count_next   = '0;
                        shift_next       = '0;
                        nack_next        = item.nack_after_read;
                        scl_next         = 1'b0;
                        phase_next       = PH_RB_L;
                        delay_count_next = step_eff;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (dc_dec != '0)
        begin
            delay_count_next = dc_dec;
        end
        else
        begin
            delay_count_next = step_eff;
            unique case (phase_reg)
                PH_ST1:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST2;
                end
                PH_ST2:
                begin
                    scl_next         = 1'b0;
                    phase_next       = PH_IDLE;
                    delay_count_next = '0;
                    done_now         = 1'b1;
                end
                PH_SP1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_SP2;
                end
                PH_SP2:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_SP3;
                end
                PH_SP3:
                begin
                    phase_next       = PH_IDLE;
                    delay_count_next = '0;
                    done_now         = 1'b1;
                end
                PH_WB_D:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WB_H;
                end
                PH_WB_H:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_WB_L;
                end
                PH_WB_L:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc < BITS_PER_BYTE)
                    begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_WB_D;
                    end
                    else
                    begin
                        sda_next        = 1'b1;
                        poll_count_next = '0;
                        phase_next      = PH_RA_R;
                    end
                end
                PH_RA_R:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RA_H;
                end
                PH_RA_H, PH_RA_P:
                begin
                    if (!item.sda_in)
                    begin
                        // ACK seen: drop SCL and finish cleanly
                        scl_next         = 1'b0;
                        error_next       = 1'b0;
                        phase_next       = PH_IDLE;
                        delay_count_next = '0;
                        done_now         = 1'b1;
                    end
                    else if (poll_count_reg >= cfg.ack_poll_limit)
                    begin
                        // Timed out: flag and run a stop sequence
                        error_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_SP1;
                    end
                    else
                    begin
                        poll_count_next  = poll_count_reg + 1'b1;
                        phase_next       = PH_RA_P;
                        delay_count_next = poll_eff;
                    end
                end
                PH_RB_L:
                begin
                    scl_next       = 1'b1;
                    shift_next     = {shift_reg[6:0], item.sda_in};
                    bit_count_next = bc_inc;
                    phase_next     = PH_RB_H;
                end
                PH_RB_H:
                begin
                    scl_next   = 1'b0;
                    phase_next = (bit_count_reg < BITS_PER_BYTE) ? PH_RB_L : PH_RB_E;
                end
                PH_RB_E:
                begin
                    scl_next   = 1'b0;
                    sda_next   = nack_reg;
                    phase_next = PH_AK_D;
                end
                PH_AK_D:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_AK_H;
                end
                PH_AK_H:
                begin
                    scl_next         = 1'b0;
                    rx_hold_next     = shift_reg;
                    phase_next       = PH_IDLE;
                    delay_count_next = '0;
                    done_now         = 1'b1;
                end
                default:
                begin
                    phase_next       = PH_IDLE;
                    delay_count_next = '0;
                end
            endcase
        end
    end

    // Hold sequencer state, advance only on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            delay_count_reg <= '0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            poll_count_reg  <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            error_reg       <= 1'b0;
            rx_hold_reg     <= '0;
            nack_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            delay_count_reg <= delay_count_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            poll_count_reg  <= poll_count_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            error_reg       <= error_next;
            rx_hold_reg     <= rx_hold_next;
            nack_reg        <= nack_next;
        end
    end

    // Output register: load a result per tick, hold it while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.scl_out     <= scl_next;
            out_data_reg.sda_release <= sda_next;
            out_data_reg.busy_res    <= (phase_next != PH_IDLE);
            out_data_reg.done_res    <= done_now;
            out_data_reg.rx_byte     <= rx_hold_next;
            out_data_reg.ack_error   <= error_next;
        end
    end

    assign res_ch.valid = out_valid_reg;
    assign res_ch.data  = out_data_reg;

    `I2CBB_ASSERT_SAME(a_delay_armed, phase_reg != PH_IDLE, delay_count_reg != '0)
    `I2CBB_ASSERT_SAME(a_bit_range, 1'b1, bit_count_reg <= BITS_PER_BYTE)
    `I2CBB_ASSERT_NEXT(a_done_idle, step && done_now, phase_reg == PH_IDLE && !res_ch.data.busy_res)
    `I2CBB_ASSERT_NEXT(a_result_follows, step, res_ch.valid)

endmodule

// File: dv/testbench.sv
// Self-checking bench for the I2C bit-bang master: ticks are driven one per transaction,
// line levels are predicted in step and compared with every result transaction.
// Depends on i2cbb_pkg, the channel interfaces in i2cbb_if and the i2c_bitbang_master RTL.
module testbench;
    import i2cbb_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic clk;
    logic rst_n;

    i2cbb_cmd_if cmd_ch ();
    i2cbb_res_if res_ch ();
    i2cbb_cfg_if cfg_ch ();

    i2c_bitbang_master u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Bus engine state as predicted, plus a copy of the delay registers
    phase_t      bus_ph    = PH_IDLE;
    logic [15:0] tick_left = '0;
    logic [3:0]  bit_n     = '0;
    logic [7:0]  shreg     = '0;
    logic [7:0]  poll_n    = '0;
    logic [7:0]  rx_last   = '0;
    logic        scl_lvl   = 1'b1;
    logic        sda_lvl   = 1'b1;
    logic        ack_err   = 1'b0;
    logic        nack_sel  = 1'b0;
    logic        done_now  = 1'b0;
    logic        bus_held  = 1'b0;
    logic [15:0] step_cfg  = STEP_TICKS_RST;
    logic [15:0] poll_cfg  = POLL_TICKS_RST;
    logic [7:0]  limit_cfg = POLL_LIMIT_RST;

    // Behaviour of the addressed device on the bus
    logic        slave_acks      = 1'b1;
    logic [7:0]  slave_ack_polls = '0;
    logic [7:0]  slave_data      = '0;

    res_t expected_levels[$];

    int  mismatches     = 0;
    int  results_seen   = 0;
    int  ticks_sent     = 0;
    int  ack_timeouts   = 0;
    int  cmd_seen [4]   = '{0, 0, 0, 0};
    int  cycle_count    = 0;
    int  hold_off_left  = 0;
    int  res_stall_left = 0;
    bit  idling_on      = 1'b0;

    // Clock, period 4
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Load a delay, a zero register counts as one tick
    function automatic void arm_delay(phase_t p, logic [15:0] ticks);
        bus_ph    = p;
        tick_left = (ticks == 16'd0) ? 16'd1 : ticks;
    endfunction

    function automatic void end_cmd();
        bus_ph    = PH_IDLE;
        tick_left = '0;
        done_now  = 1'b1;
    endfunction

    function automatic void begin_stop();
        scl_lvl  = 1'b0;
        sda_lvl  = 1'b0;
        bus_held = 1'b0;
        arm_delay(PH_SP1, step_cfg);
    endfunction

    function automatic void shift_out_bit();
        sda_lvl = shreg[7];
        shreg   = {shreg[6:0], 1'b0};
        arm_delay(PH_WB_D, step_cfg);
    endfunction

    // Advance the predicted engine by one tick and return the line levels
    function automatic res_t bus_predict(cmd_t c);
        res_t r;
        done_now = 1'b0;
        if (bus_ph == PH_IDLE)
        begin
            if (c.cmd_valid)
            begin
                cmd_seen[c.func]++;
                case (func_t'(c.func))
                    FUNC_START:
                    begin
                        sda_lvl  = 1'b1;
                        scl_lvl  = 1'b1;
                        bus_held = 1'b1;
                        arm_delay(PH_ST1, step_cfg);
                    end
                    FUNC_STOP:
                        begin_stop();
                    FUNC_WRITE:
                    begin
                        shreg   = c.tx_byte;
                        bit_n   = '0;
                        scl_lvl = 1'b0;
                        shift_out_bit();
                    end
                    default:
                    begin
                        sda_lvl  = 1'b1;
                        bit_n    = '0;
                        shreg    = '0;
                        nack_sel = c.nack_after_read;
                        scl_lvl  = 1'b0;
                        arm_delay(PH_RB_L, step_cfg);
                    end
                endcase
            end
        end
        else
        begin
            tick_left = tick_left - 16'd1;
            if (tick_left == 16'd0)
            begin
                case (bus_ph)
                    PH_ST1:
                    begin
                        sda_lvl = 1'b0;
                        arm_delay(PH_ST2, step_cfg);
                    end
                    PH_ST2:
                    begin
                        scl_lvl = 1'b0;
                        end_cmd();
                    end
                    PH_SP1:
                    begin
                        scl_lvl = 1'b1;
                        arm_delay(PH_SP2, step_cfg);
                    end
                    PH_SP2:
                    begin
                        sda_lvl = 1'b1;
                        arm_delay(PH_SP3, step_cfg);
                    end
                    PH_SP3:
                        end_cmd();
                    PH_WB_D:
                    begin
                        scl_lvl = 1'b1;
                        arm_delay(PH_WB_H, step_cfg);
                    end
                    PH_WB_H:
                    begin
                        scl_lvl = 1'b0;
                        arm_delay(PH_WB_L, step_cfg);
                    end
                    PH_WB_L:
                    begin
                        bit_n = bit_n + 4'd1;
                        if (bit_n < BITS_PER_BYTE)
                            shift_out_bit();
                        else
                        begin
                            sda_lvl = 1'b1;
                            poll_n  = '0;
                            arm_delay(PH_RA_R, step_cfg);
                        end
                    end
                    PH_RA_R:
                    begin
                        scl_lvl = 1'b1;
                        arm_delay(PH_RA_H, step_cfg);
                    end
                    // Sample the ACK; give up with a stop once the limit is passed
                    PH_RA_H, PH_RA_P:
                    begin
                        if (!c.sda_in)
                        begin
                            scl_lvl = 1'b0;
                            ack_err = 1'b0;
                            end_cmd();
                        end
                        else if (poll_n >= limit_cfg)
                        begin
                            ack_err = 1'b1;
                            ack_timeouts++;
                            begin_stop();
                        end
                        else
                        begin
                            poll_n = poll_n + 8'd1;
                            arm_delay(PH_RA_P, poll_cfg);
                        end
                    end
                    PH_RB_L:
                    begin
                        scl_lvl = 1'b1;
                        shreg   = {shreg[6:0], c.sda_in};
                        bit_n   = bit_n + 4'd1;
                        arm_delay(PH_RB_H, step_cfg);
                    end
                    PH_RB_H:
                    begin
                        scl_lvl = 1'b0;
                        arm_delay((bit_n < BITS_PER_BYTE) ? PH_RB_L : PH_RB_E, step_cfg);
                    end
                    PH_RB_E:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = nack_sel;
                        arm_delay(PH_AK_D, step_cfg);
                    end
                    PH_AK_D:
                    begin
                        scl_lvl = 1'b1;
                        arm_delay(PH_AK_H, step_cfg);
                    end
                    PH_AK_H:
                    begin
                        scl_lvl = 1'b0;
                        rx_last = shreg;
                        end_cmd();
                    end
                    default:
                    begin
                        bus_ph    = PH_IDLE;
                        tick_left = '0;
                    end
                endcase
            end
        end
        r.scl_out     = scl_lvl;
        r.sda_release = sda_lvl;
        r.busy_res    = (bus_ph != PH_IDLE);
        r.done_res    = done_now;
        r.rx_byte     = rx_last;
        r.ack_error   = ack_err;
        return r;
    endfunction

    // Build one tick; SDA follows the device model where it matters, else random
    function automatic cmd_t bus_tick(logic v, func_t f, logic [7:0] b, logic nk);
        cmd_t c;
        c.cmd_valid       = v;
        c.func            = f;
        c.tx_byte         = b;
        c.nack_after_read = nk;
        c.sda_in          = 1'($urandom_range(0, 1));
        if (bus_ph == PH_RA_H || bus_ph == PH_RA_P)
            c.sda_in = (slave_acks && poll_n >= slave_ack_polls) ? 1'b0 : 1'b1;
        else if (bus_ph == PH_RB_L)
            c.sda_in = slave_data[3'd7 - bit_n[2:0]];
        return c;
    endfunction

    // Tick with an occasional stray command, ignored while the engine is busy
    function automatic cmd_t filler_tick();
        return bus_tick($urandom_range(0, 15) == 0, func_t'($urandom_range(0, 3)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void arm_slave();
        slave_acks      = ($urandom_range(0, 5) != 0);
        slave_ack_polls = 8'($urandom_range(0, 3));
        slave_data      = 8'($urandom_range(0, 255));
    endfunction

    // Offer one tick, wait for the transaction and record the expected levels
    task automatic send_tick(input cmd_t c);
        int gap;
        if (idling_on && $urandom_range(0, 15) == 0)
        begin
            gap = $urandom_range(1, 11);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        expected_levels.push_back(bus_predict(c));
        ticks_sent++;
    endtask

    task automatic release_cmd();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
    endtask

    // Run the engine back to idle and drain every outstanding result
    task automatic settle_bus();
        while (bus_ph != PH_IDLE)
            send_tick(filler_tick());
        release_cmd();
        while (expected_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_STEP_TICKS: step_cfg  = val;
            REG_POLL_TICKS: poll_cfg  = val;
            default:        limit_cfg = val[7:0];
        endcase
    endtask

    task automatic write_cfg(input logic [15:0] step, input logic [15:0] poll,
                             input logic [7:0] limit);
        settle_bus();
        cfg_write(REG_STEP_TICKS, step);
        cfg_write(REG_POLL_TICKS, poll);
        cfg_write(REG_POLL_LIMIT, {8'd0, limit});
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Issue a command to the idle engine and tick until it completes
    task automatic bus_cmd(input func_t f, input logic [7:0] b, input logic nk);
        send_tick(bus_tick(1'b1, f, b, nk));
        while (bus_ph != PH_IDLE)
            send_tick(filler_tick());
    endtask

    // Full frame at the reset timing: byte extremes, ACK after polls, ACK and NACK reads
    task automatic test_default_frame();
        slave_acks      = 1'b1;
        slave_ack_polls = 8'd0;
        bus_cmd(FUNC_START, 8'h00, 1'b0);
        bus_cmd(FUNC_WRITE, 8'h00, 1'b0);
        slave_ack_polls = 8'd3;
        bus_cmd(FUNC_WRITE, 8'hFF, 1'b0);
        slave_data = 8'hA5;
        bus_cmd(FUNC_READ, 8'h00, 1'b0);
        slave_data = 8'h00;
        bus_cmd(FUNC_READ, 8'h00, 1'b1);
        slave_data = 8'hFF;
        bus_cmd(FUNC_READ, 8'hFF, 1'b0);
        bus_cmd(FUNC_STOP, 8'h00, 1'b0);
    endtask

    // Hold results back long enough for the command queue to fill
    task automatic test_backpressure();
        hold_off_left = 48;
        bus_cmd(FUNC_START, 8'h00, 1'b0);
        repeat (40)
            send_tick(filler_tick());
        bus_cmd(FUNC_STOP, 8'h00, 1'b0);
    endtask

    // Missing ACK, error kept by start/read/stop, cleared by the next good ACK
    task automatic test_ack_timeout();
        write_cfg(16'd1, 16'd1, 8'd1);
        slave_acks = 1'b0;
        bus_cmd(FUNC_START, 8'h00, 1'b0);
        bus_cmd(FUNC_WRITE, 8'h5A, 1'b0);
        slave_data = 8'h3C;
        bus_cmd(FUNC_START, 8'h00, 1'b0);
        bus_cmd(FUNC_READ, 8'h00, 1'b1);
        bus_cmd(FUNC_STOP, 8'h00, 1'b0);
        slave_acks      = 1'b1;
        slave_ack_polls = 8'd1;
        bus_cmd(FUNC_START, 8'h00, 1'b0);
        bus_cmd(FUNC_WRITE, 8'hC3, 1'b0);
        // Widest poll limit: a full timeout
        write_cfg(16'd1, 16'd1, 8'd255);
        slave_acks = 1'b0;
        bus_cmd(FUNC_WRITE, 8'h7E, 1'b0);
        // Stop and read outside a frame
        bus_cmd(FUNC_STOP, 8'h00, 1'b0);
        slave_data = 8'h96;
        bus_cmd(FUNC_READ, 8'h00, 1'b0);
    endtask

    // Zero delays run as one tick; a zero limit fails on the first high sample
    task automatic test_zero_registers();
        write_cfg(16'd0, 16'd0, 8'd0);
        slave_acks      = 1'b1;
        slave_ack_polls = 8'd0;
        bus_cmd(FUNC_START, 8'h00, 1'b0);
        bus_cmd(FUNC_WRITE, 8'h3C, 1'b0);
        slave_acks = 1'b0;
        bus_cmd(FUNC_WRITE, 8'hE7, 1'b0);
        slave_data = 8'h69;
        bus_cmd(FUNC_READ, 8'h00, 1'b1);
        bus_cmd(FUNC_STOP, 8'h00, 1'b0);
    endtask

    // Long step and poll delays, well past the reset timing
    task automatic test_long_delays();
        write_cfg(16'd37, 16'd2, 8'd250);
        bus_cmd(FUNC_START, 8'h00, 1'b0);
        write_cfg(16'd1, 16'd91, 8'd1);
        slave_acks      = 1'b1;
        slave_ack_polls = 8'd1;
        bus_cmd(FUNC_WRITE, 8'h96, 1'b0);
        bus_cmd(FUNC_STOP, 8'h00, 1'b0);
    endtask

    // Mostly well-formed frames with random content, some stray and idle ticks
    task automatic test_random_traffic(input int n_items);
        int   r;
        int   sent;
        cmd_t c;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (bus_ph != PH_IDLE)
                c = filler_tick();
            else
            begin
                arm_slave();
                if (r < 15)
                    c = bus_tick(1'b0, func_t'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else if (!bus_held)
                begin
                    if (r < 88)
                        c = bus_tick(1'b1, FUNC_START, 8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)));
                    else
                        c = bus_tick(1'b1, func_t'($urandom_range(1, 3)),
                                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                else if (r < 58)
                    c = bus_tick(1'b1, FUNC_WRITE, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
                else if (r < 82)
                    c = bus_tick(1'b1, FUNC_READ, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
                else
                    c = bus_tick(1'b1, FUNC_STOP, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
            end
            send_tick(c);
            sent++;
        end
    endtask

    // Result side: random stalls in bursts, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            res_ch.ready <= 1'b0;
        end
        else if (res_stall_left > 0)
        begin
            res_stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 11) == 0)
        begin
            res_stall_left = $urandom_range(0, 10);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_levels
        res_t want;
        res_t got;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = res_ch.data;
            if (expected_levels.size() == 0)
            begin
                $error("result transaction with no tick outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_levels.pop_front();
                results_seen++;
                check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
                check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int waited;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.idx   = '0;
        cfg_ch.wdata = '0;
        res_ch.ready = 1'b0;
        rst_n        = 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idling_on = 1'b1;
        test_default_frame();
        test_backpressure();
        test_ack_timeout();
        test_zero_registers();
        test_long_delays();

        write_cfg(16'd1, 16'd1, 8'd3);
        test_random_traffic(50);
        write_cfg(16'd2, 16'd3, 8'd20);
        test_random_traffic(50);
        write_cfg(16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)),
                  8'($urandom_range(1, 8)));
        test_random_traffic(50);
        settle_bus();
        idling_on = 1'b0;
        write_cfg(16'd1, 16'd2, 8'd2);
        test_random_traffic(40);

        // Let the last results out, then look for anything left behind
        release_cmd();
        waited = 0;
        while (expected_levels.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8)
            @(posedge clk);
        if (expected_levels.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_levels.size());
            mismatches++;
        end

        $display("%0d ticks sent, %0d results checked, %0d mismatches",
                 ticks_sent, results_seen, mismatches);
        $display("commands taken: start %0d, stop %0d, write %0d, read %0d; ACK timeouts %0d",
                 cmd_seen[FUNC_START], cmd_seen[FUNC_STOP], cmd_seen[FUNC_WRITE],
                 cmd_seen[FUNC_READ], ack_timeouts);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
